[hw/rtl/update_packet_checker_macros.svh]
// assertion macros for the update packet checker
// used by hw/rtl/update_packet_checker.sv, needs a signal named clock and one named reset
`ifndef UPDATE_PACKET_CHECKER_MACROS_SVH
`define UPDATE_PACKET_CHECKER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define UPC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/upc_pkg.sv]
// shared types and constants of the update packet checker
// no dependencies; imported by every rtl module of the block
package upc_pkg;

   // parser phases
   localparam int unsigned PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SRC   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CMD   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;
   localparam logic [PHASE_W-1:0] PH_TAIL  = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HEADER   = 3'd1;
   localparam logic [2:0] ST_SOURCE   = 3'd2;
   localparam logic [2:0] ST_LENGTH   = 3'd3;
   localparam logic [2:0] ST_CHECKSUM = 3'd4;
   localparam logic [2:0] ST_TAIL     = 3'd5;

   // frame constants
   localparam logic [7:0]  FRAME_MARK     = 8'hFF;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
   localparam logic [16:0] MIN_OK_LENGTH  = 17'd12;
   localparam logic [15:0] FIRST_DATA_NO  = 16'd2;
   localparam logic [15:0] END_NO         = 16'hFF00;
   localparam logic [15:0] MIN_DATA_LEN   = 16'd2;

   // csr map
   localparam logic       CSR_EXPECTED_SOURCE = 1'b0;
   localparam logic       CSR_MAX_DATA_LENGTH = 1'b1;
   localparam logic [7:0]  SOURCE_RESET  = 8'd0;
   localparam logic [15:0] MAX_LEN_RESET = 16'd64502;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] command_word;
      logic [15:0] packet_number;
      logic        is_data_packet;
      logic [16:0] frame_length;
   } upc_result_type;

endpackage

[hw/rtl/upc_parser.sv]
// frame parser: per-byte state update and result formation
// depends on upc_pkg
module upc_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              rx_byte,
   input  logic [7:0]              expected_source,
   input  logic [15:0]             max_data_length,
   output logic                    res_valid,
   output upc_pkg::upc_result_type res
);
   import upc_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] data_length_ff, data_length_in;
   logic [31:0] command_acc_ff, command_acc_in;
   logic [15:0] number_acc_ff, number_acc_in;
   logic [7:0]  sum_acc_ff, sum_acc_in;
   logic [7:0]  received_check_ff, received_check_in;

   logic [15:0] len_full;
   logic [15:0] count_next;
   logic [31:0] cmd_shifted;
   logic        is_data;

   assign len_full    = {rx_byte, data_length_ff[7:0]};
   assign count_next  = byte_count_ff + 16'd1;
   assign cmd_shifted = {24'd0, rx_byte} << {byte_count_ff[1:0], 3'b000};
   assign is_data     = (number_acc_ff >= FIRST_DATA_NO) && (number_acc_ff < END_NO);

   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      data_length_in    = data_length_ff;
      command_acc_in    = command_acc_ff;
      number_acc_in     = number_acc_ff;
      sum_acc_in        = sum_acc_ff;
      received_check_in = received_check_ff;
      res_valid         = 1'b0;
      res               = '0;
      case (phase_ff)
         PH_SRC: begin
            if (rx_byte != expected_source) begin
               res_valid      = 1'b1;
               res.status     = ST_SOURCE;
               phase_in       = PH_HUNT;
               byte_count_in  = '0;
               data_length_in = '0;
               command_acc_in = '0;
               number_acc_in  = '0;
               sum_acc_in     = '0;
               received_check_in = '0;
            end else begin
               phase_in      = PH_LEN;
               byte_count_in = '0;
            end
         end
         PH_LEN: begin
            if (byte_count_ff == 16'd0) begin
               data_length_in = {8'd0, rx_byte};
               byte_count_in  = 16'd1;
            end else if ((len_full < MIN_DATA_LEN) || (len_full > max_data_length)) begin
               res_valid         = 1'b1;
               res.status        = ST_LENGTH;
               res.frame_length  = {1'b0, len_full} + FRAME_OVERHEAD;
               phase_in          = PH_HUNT;
               byte_count_in     = '0;
               data_length_in    = '0;
               command_acc_in    = '0;
               number_acc_in     = '0;
               sum_acc_in        = '0;
               received_check_in = '0;
            end else begin
               data_length_in = len_full;
               phase_in       = PH_CMD;
               byte_count_in  = '0;
            end
         end
         PH_CMD: begin
            command_acc_in = command_acc_ff | cmd_shifted;
            if (byte_count_ff >= 16'd3) begin
               phase_in      = PH_DATA;
               byte_count_in = '0;
            end else begin
               byte_count_in = count_next;
            end
         end
         PH_DATA: begin
            if (byte_count_ff == 16'd0) begin
               number_acc_in = {8'd0, rx_byte};
            end else if (byte_count_ff == 16'd1) begin
               number_acc_in = {rx_byte, number_acc_ff[7:0]};
            end else begin
               sum_acc_in = sum_acc_ff + rx_byte;
            end
            byte_count_in = count_next;
            if (count_next >= data_length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            received_check_in = rx_byte;
            phase_in          = PH_TAIL;
         end
         PH_TAIL: begin
            res_valid = 1'b1;
            if (is_data && (sum_acc_ff != received_check_ff)) begin
               res.status = ST_CHECKSUM;
            end else if (rx_byte != FRAME_MARK) begin
               res.status = ST_TAIL;
            end else begin
               res.status = ST_OK;
            end
            res.command_word   = command_acc_ff;
            res.packet_number  = number_acc_ff;
            res.is_data_packet = is_data;
            res.frame_length   = {1'b0, data_length_ff} + FRAME_OVERHEAD;
            phase_in           = PH_HUNT;
            byte_count_in      = '0;
            data_length_in     = '0;
            command_acc_in     = '0;
            number_acc_in      = '0;
            sum_acc_in         = '0;
            received_check_in  = '0;
         end
         default: begin
            // hunting, and any phase code that means nothing
            if (rx_byte != FRAME_MARK) begin
               res_valid  = 1'b1;
               res.status = ST_HEADER;
               phase_in   = PH_HUNT;
            end else begin
               phase_in = PH_SRC;
            end
            byte_count_in     = '0;
            data_length_in    = '0;
            command_acc_in    = '0;
            number_acc_in     = '0;
            sum_acc_in        = '0;
            received_check_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         byte_count_ff     <= '0;
         data_length_ff    <= '0;
         command_acc_ff    <= '0;
         number_acc_ff     <= '0;
         sum_acc_ff        <= '0;
         received_check_ff <= '0;
      end else if (step_en) begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         data_length_ff    <= data_length_in;
         command_acc_ff    <= command_acc_in;
         number_acc_ff     <= number_acc_in;
         sum_acc_ff        <= sum_acc_in;
         received_check_ff <= received_check_in;
      end
   end

endmodule

[hw/rtl/upc_out_reg.sv]
// result register between the parser and the response channel
// depends on upc_pkg
module upc_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   input  upc_pkg::upc_result_type load_data,
   input  logic                    rsp_stall,
   output logic                    can_load,
   output logic                    out_valid,
   output upc_pkg::upc_result_type out_data
);
   import upc_pkg::*;

   logic           valid_ff, valid_in;
   upc_result_type data_ff;

   // free when empty or when the held response leaves this cycle
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = can_load ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/update_packet_checker.sv]
// top level of the update packet checker: input register, parser, result register, csrs
// depends on upc_pkg, upc_parser, upc_out_reg and update_packet_checker_macros.svh
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall  | status, command word, number, flag, length
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// one request per cycle sustained while rsp is not stalled; a request is parsed once
// it sits in the input register and the result register can take its outcome, and its
// response (if any) shows on rsp the cycle after that, so bytes stream back to back
// reset is synchronous and active high; it clears the parser to hunting and csrs to defaults
// a stalled response holds the result register; the parser then waits and req_stall rises
// once the input register is also full
module update_packet_checker (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_command_word,
   output logic [15:0] rsp_packet_number,
   output logic        rsp_is_data_packet,
   output logic [16:0] rsp_frame_length,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import upc_pkg::*;

   `include "update_packet_checker_macros.svh"

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // csrs
   logic [7:0]  expected_source_ff;
   logic [15:0] max_data_length_ff;

   // handshake between stages
   logic           advance;
   logic           out_can_load;
   logic           res_valid;
   upc_result_type res;
   upc_result_type out_data;

   // parser steps on the held byte when the result register can take its outcome
   assign advance     = in_valid_ff && out_can_load;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // csr writes land at once; always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_source_ff <= SOURCE_RESET;
         max_data_length_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPECTED_SOURCE: expected_source_ff <= csr_wdata[7:0];
            CSR_MAX_DATA_LENGTH: max_data_length_ff <= csr_wdata;
            default: begin
               expected_source_ff <= expected_source_ff;
            end
         endcase
      end
   end

   // frame parser
   upc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .rx_byte         (in_byte_ff),
      .expected_source (expected_source_ff),
      .max_data_length (max_data_length_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   // result register, only loaded while the parser steps
   upc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid && advance),
      .load_data  (res),
      .rsp_stall  (rsp_stall),
      .can_load   (out_can_load),
      .out_valid  (rsp_valid),
      .out_data   (out_data)
   );

   assign rsp_status         = out_data.status;
   assign rsp_command_word   = out_data.command_word;
   assign rsp_packet_number  = out_data.packet_number;
   assign rsp_is_data_packet = out_data.is_data_packet;
   assign rsp_frame_length   = out_data.frame_length;

   // a good frame carries at least the packet number, so the length covers it
   `UPC_ASSERT_SAME(a_ok_length, rsp_valid && (rsp_status == ST_OK),
      rsp_frame_length >= MIN_OK_LENGTH, "ok response with short frame length")

   // a header miss reports no frame fields
   `UPC_ASSERT_SAME(a_header_clean, rsp_valid && (rsp_status == ST_HEADER),
      (rsp_command_word == 32'd0) && (rsp_frame_length == 17'd0),
      "header error carries frame fields")

   // the data flag agrees with the reported packet number
   `UPC_ASSERT_SAME(a_data_flag, rsp_valid && rsp_is_data_packet,
      (rsp_packet_number >= FIRST_DATA_NO) && (rsp_packet_number < END_NO),
      "data flag set outside data packet range")

   // a request stalled at the port was already waiting in the input register
   `UPC_ASSERT_NEXT(a_stall_holds, req_stall && in_valid_ff, in_valid_ff,
      "input register lost a stalled byte")

endmodule
